// File: rtl/ibrx_pkg.sv
// ----------------------------------------------------------------------------
// ibrx_pkg
// Shared types and constants for the RC serial frame receiver.
// ----------------------------------------------------------------------------
package ibrx_pkg;

	// Default structure of a frame
	localparam int BASE_SLOTS_DEF   = 14;
	localparam int MAX_CHANNELS_DEF = 18;

	// Frame lengths and start bytes
	localparam int          RX_FRAME_LEN    = 32;
	localparam int          TELEM_FRAME_LEN = 4;
	localparam int          OLD_FRAME_LEN   = 31;
	localparam logic [7:0]  OLD_START       = 8'h55;

	// Older model: words summed over bytes 1 .. len-3
	localparam int OLD_SUM_FIRST = 1;
	localparam int OLD_SUM_LAST  = OLD_FRAME_LEN - 3;

	// Newer model checksum seed
	localparam logic [15:0] NEW_SUM_SEED = 16'hFFFF;

	// Field widths
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 6;
	localparam int CNT_W  = 5;
	localparam int VAL_W  = 12;
	localparam int SUM_W  = 16;

	// Frame store geometry
	localparam int STORE_DEPTH = RX_FRAME_LEN;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	// Register reset
	localparam logic [CNT_W-1:0] CHANNEL_COUNT_RST = 5'd14;

	// Frame completion from the byte intake to the result sequencer
	typedef struct packed {
		logic fire;   // last byte of a frame transferred this cycle
		logic err;    // checksum mismatch
		logic telem;  // telemetry frame, status only
		logic model;  // 1 newer length-prefixed, 0 older
	} frame_end_t;

	// Result sequencer states
	typedef enum logic [2:0] {
		EM_IDLE,
		EM_READ,
		EM_FINISH,
		EM_PUT,
		EM_SINGLE
	} emit_state_t;

endpackage

// File: rtl/ibrx_if.sv
// ----------------------------------------------------------------------------
// ibrx_if
// Valid/ready channels of the receiver: received bytes, results, register.
// ----------------------------------------------------------------------------

// Received byte channel
interface ibrx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel
interface ibrx_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic        has_value;
	logic [4:0]  channel_index;
	logic [11:0] channel_value;
	logic        receiver_model;
	logic        last;

	modport source (output valid, output status, output has_value, output channel_index,
		output channel_value, output receiver_model, output last, input ready);
	modport sink   (input valid, input status, input has_value, input channel_index,
		input channel_value, input receiver_model, input last, output ready);
endinterface

// Register write channel
interface ibrx_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] channel_count;

	modport source (output valid, output channel_count, input ready);
	modport sink   (input valid, input channel_count, output ready);
endinterface

// File: rtl/ibrx_store.sv
// ----------------------------------------------------------------------------
// ibrx_store
// Frame byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ibrx_store (
	input  logic                         clk,
	input  logic                         we,
	input  logic [ibrx_pkg::STORE_AW-1:0] waddr,
	input  logic [ibrx_pkg::BYTE_W-1:0]   wdata,
	input  logic                         re,
	input  logic [ibrx_pkg::STORE_AW-1:0] raddr,
	output logic [ibrx_pkg::BYTE_W-1:0]   rdata
);

	logic [ibrx_pkg::BYTE_W-1:0] mem [ibrx_pkg::STORE_DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/ibrx_intake.sv
// ----------------------------------------------------------------------------
// ibrx_intake
// Start byte hunt, frame position, running checksum and store writes.
// ----------------------------------------------------------------------------
module ibrx_intake (
	input  logic                          clk,
	input  logic                          arst_n,
	ibrx_byte_if.sink                     rx,
	input  logic                          busy,
	output logic                          st_we,
	output logic [ibrx_pkg::STORE_AW-1:0] st_waddr,
	output logic [ibrx_pkg::BYTE_W-1:0]   st_wdata,
	output ibrx_pkg::frame_end_t          fe
);

	// Frame state
	logic                          in_frame_q;
	logic                          model_q;
	logic [ibrx_pkg::BYTE_W-1:0]   sync_q;
	logic [ibrx_pkg::LEN_W-1:0]    len_q;
	logic [ibrx_pkg::LEN_W-1:0]    wp_q;
	logic [ibrx_pkg::SUM_W-1:0]    sum_q;
	logic [ibrx_pkg::BYTE_W-1:0]   trail_q;

	logic                          xfer;
	logic [ibrx_pkg::BYTE_W-1:0]   b;
	logic                          start_new;
	logic                          start_old;
	logic                          start_rpt;
	logic                          take;
	logic                          cur_model;
	logic [ibrx_pkg::LEN_W-1:0]    cur_len;
	logic [ibrx_pkg::LEN_W-1:0]    pos;
	logic [ibrx_pkg::SUM_W-1:0]    sum_cur;
	logic [ibrx_pkg::SUM_W-1:0]    sum_next;
	logic                          frame_done;
	logic                          trail_pos;

	assign rx.ready = !busy;
	assign xfer     = rx.valid && rx.ready;
	assign b        = rx.rx_byte;

	// Start byte decode while hunting
	always_comb begin
		start_new = (b == 8'(ibrx_pkg::RX_FRAME_LEN)) || (b == 8'(ibrx_pkg::TELEM_FRAME_LEN));
		start_old = (sync_q == '0) && (b == ibrx_pkg::OLD_START);
		start_rpt = (sync_q != '0) && (sync_q == b);
		take      = in_frame_q || start_new || start_old || start_rpt;

		cur_model = model_q;
		cur_len   = len_q;
		if (!in_frame_q && start_new) begin
			cur_model = 1'b1;
			cur_len   = b[ibrx_pkg::LEN_W-1:0];
		end else if (!in_frame_q && start_old) begin
			cur_model = 1'b0;
			cur_len   = 6'(ibrx_pkg::OLD_FRAME_LEN);
		end
		pos = in_frame_q ? wp_q : '0;
	end

	// Running checksum
	always_comb begin
		if (in_frame_q) begin
			sum_cur = sum_q;
		end else begin
			sum_cur = cur_model ? ibrx_pkg::NEW_SUM_SEED : '0;
		end
		sum_next = sum_cur;
		if (cur_model) begin
			if (({1'b0, pos} + 7'd2) < {1'b0, cur_len}) begin
				sum_next = sum_cur - {8'h00, b};
			end
		end else if (pos >= 6'(ibrx_pkg::OLD_SUM_FIRST) && pos <= 6'(ibrx_pkg::OLD_SUM_LAST)) begin
			// odd byte is the low half of a word
			sum_next = pos[0] ? (sum_cur + {8'h00, b}) : (sum_cur + {b, 8'h00});
		end
		frame_done = ({1'b0, pos} + 7'd1) == {1'b0, cur_len};
		trail_pos  = ({1'b0, pos} + 7'd2) == {1'b0, cur_len};
	end

	// Store write and frame completion
	always_comb begin
		st_we    = xfer && take;
		st_waddr = pos[ibrx_pkg::STORE_AW-1:0];
		st_wdata = b;
		fe.fire  = xfer && take && frame_done;
		fe.err   = sum_cur != {b, trail_q};
		fe.telem = cur_model && (cur_len == 6'(ibrx_pkg::TELEM_FRAME_LEN));
		fe.model = cur_model;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			model_q    <= 1'b0;
			sync_q     <= '0;
			len_q      <= '0;
			wp_q       <= '0;
		end else if (xfer && take) begin
			in_frame_q <= !frame_done;
			model_q    <= cur_model;
			len_q      <= cur_len;
			wp_q       <= pos + 6'd1;
			if (!in_frame_q && (start_new || start_old)) begin
				sync_q <= b;
			end
		end
	end

	// Checksum datapath
	always_ff @(posedge clk) begin
		if (xfer && take) begin
			sum_q <= sum_next;
			if (trail_pos) begin
				trail_q <= b;
			end
		end
	end

endmodule

// File: rtl/ibrx_emit.sv
// ----------------------------------------------------------------------------
// ibrx_emit
// Result sequencer: reads channel bytes from the store, builds 12-bit
// channel values and loads them into the output register.
// ----------------------------------------------------------------------------
module ibrx_emit #(
	parameter int BASE_SLOTS   = ibrx_pkg::BASE_SLOTS_DEF,
	parameter int MAX_CHANNELS = ibrx_pkg::MAX_CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ibrx_pkg::frame_end_t          fe,
	input  logic [ibrx_pkg::CNT_W-1:0]    channel_count,
	output logic                          busy,
	output logic                          st_re,
	output logic [ibrx_pkg::STORE_AW-1:0] st_raddr,
	input  logic [ibrx_pkg::BYTE_W-1:0]   st_rdata,
	ibrx_res_if.source                    res
);

	ibrx_pkg::emit_state_t state_q, state_d;

	logic [ibrx_pkg::CNT_W-1:0]    ch_q;
	logic [ibrx_pkg::CNT_W-1:0]    n_q;
	logic [ibrx_pkg::STORE_AW-1:0] ch_addr_q;
	logic [1:0]                    sel_q, sel_d;
	logic                          re_s1;
	logic [1:0]                    sel_s1;
	logic                          model_q;
	logic                          err_q;
	logic [ibrx_pkg::VAL_W-1:0]    val_q;

	logic                          out_valid_q;
	logic                          out_status_q;
	logic                          out_has_q;
	logic [ibrx_pkg::CNT_W-1:0]    out_idx_q;
	logic [ibrx_pkg::VAL_W-1:0]    out_val_q;
	logic                          out_model_q;
	logic                          out_last_q;

	logic [ibrx_pkg::CNT_W-1:0]    n;
	logic                          single;
	logic                          is_ext;
	logic [1:0]                    last_sel;
	logic                          ch_last;
	logic                          out_free;
	logic                          load_ch;
	logic                          load_one;
	logic [ibrx_pkg::STORE_AW-1:0] off;
	logic [ibrx_pkg::STORE_AW-1:0] ch_addr_next;

	// Channel count clipped to the maximum
	always_comb begin
		n      = (channel_count > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : channel_count;
		single = fe.err || fe.telem || (n == '0);
	end

	// Per-channel addressing
	always_comb begin
		is_ext   = ch_q >= 5'(BASE_SLOTS);
		last_sel = is_ext ? 2'd2 : 2'd1;
		ch_last  = (ch_q + 5'd1) == n_q;
		off      = model_q ? 5'd2 : 5'd1;
		if (is_ext) begin
			st_raddr = ch_addr_q + {2'b00, sel_q, 1'b0};
		end else begin
			st_raddr = ch_addr_q + {3'b000, sel_q};
		end
		if ((ch_q + 5'd1) == 5'(BASE_SLOTS)) begin
			ch_addr_next = off + 5'd1;
		end else if (!is_ext) begin
			ch_addr_next = ch_addr_q + 5'd2;
		end else begin
			ch_addr_next = ch_addr_q + 5'd6;
		end
		out_free = !out_valid_q || res.ready;
		busy     = state_q != ibrx_pkg::EM_IDLE;
	end

	// Next state and strobes
	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		st_re    = 1'b0;
		load_ch  = 1'b0;
		load_one = 1'b0;
		unique case (state_q)
			ibrx_pkg::EM_IDLE: begin
				if (fe.fire) begin
					state_d = single ? ibrx_pkg::EM_SINGLE : ibrx_pkg::EM_READ;
				end
			end
			ibrx_pkg::EM_READ: begin
				st_re = 1'b1;
				if (sel_q == last_sel) begin
					sel_d   = 2'd0;
					state_d = ibrx_pkg::EM_FINISH;
				end else begin
					sel_d = sel_q + 2'd1;
				end
			end
			ibrx_pkg::EM_FINISH: begin
				state_d = ibrx_pkg::EM_PUT;
			end
			ibrx_pkg::EM_PUT: begin
				if (out_free) begin
					load_ch = 1'b1;
					state_d = ch_last ? ibrx_pkg::EM_IDLE : ibrx_pkg::EM_READ;
				end
			end
			ibrx_pkg::EM_SINGLE: begin
				if (out_free) begin
					load_one = 1'b1;
					state_d  = ibrx_pkg::EM_IDLE;
				end
			end
			default: begin
				state_d = ibrx_pkg::EM_IDLE;
			end
		endcase
	end

	// State register and channel counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibrx_pkg::EM_IDLE;
			sel_q   <= '0;
			re_s1   <= 1'b0;
			ch_q    <= '0;
			n_q     <= '0;
			model_q <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			re_s1   <= st_re;
			if (state_q == ibrx_pkg::EM_IDLE && fe.fire) begin
				ch_q    <= '0;
				n_q     <= n;
				model_q <= fe.model;
				err_q   <= fe.err;
			end else if (load_ch) begin
				ch_q <= ch_q + 5'd1;
			end
		end
	end

	// Channel address and value assembly
	always_ff @(posedge clk) begin
		sel_s1 <= sel_q;
		if (state_q == ibrx_pkg::EM_IDLE && fe.fire) begin
			ch_addr_q <= fe.model ? 5'd2 : 5'd1;
		end else if (load_ch) begin
			ch_addr_q <= ch_addr_next;
		end
		if (re_s1) begin
			if (is_ext) begin
				// high nibbles of three bytes
				case (sel_s1)
					2'd0:    val_q[3:0]  <= st_rdata[7:4];
					2'd1:    val_q[7:4]  <= st_rdata[7:4];
					2'd2:    val_q[11:8] <= st_rdata[7:4];
					default: val_q       <= val_q;
				endcase
			end else begin
				// low byte then low nibble of the next
				case (sel_s1)
					2'd0:    val_q[7:0]  <= st_rdata;
					2'd1:    val_q[11:8] <= st_rdata[3:0];
					default: val_q       <= val_q;
				endcase
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_ch || load_one) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_ch) begin
			out_status_q <= 1'b0;
			out_has_q    <= 1'b1;
			out_idx_q    <= ch_q;
			out_val_q    <= val_q;
			out_model_q  <= model_q;
			out_last_q   <= ch_last;
		end else if (load_one) begin
			out_status_q <= err_q;
			out_has_q    <= 1'b0;
			out_idx_q    <= '0;
			out_val_q    <= '0;
			out_model_q  <= model_q;
			out_last_q   <= 1'b1;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.status         = out_status_q;
	assign res.has_value      = out_has_q;
	assign res.channel_index  = out_idx_q;
	assign res.channel_value  = out_val_q;
	assign res.receiver_model = out_model_q;
	assign res.last           = out_last_q;

endmodule

// File: rtl/ibus_rc_frame_receiver.sv
// ----------------------------------------------------------------------------
// ibus_rc_frame_receiver
// RC serial link frame receiver: byte in, checked channel results out.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while no results are being built. The
// checksum runs as bytes arrive and every byte of a frame lands in a 32 x 8
// frame store. On the last byte of a frame the byte input stalls while the
// result sequencer works: an error, telemetry or zero-channel frame gives one
// result; otherwise each 12-bit word channel reads two bytes and each
// high-nibble channel three bytes through the single read port of the frame
// store (one byte per cycle, registered read data), then the output load.
// Stalls on the result side also hold the byte input. Bytes are taken again
// as soon as the last result is in the output register. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module ibus_rc_frame_receiver #(
	parameter int BASE_SLOTS   = ibrx_pkg::BASE_SLOTS_DEF,
	parameter int MAX_CHANNELS = ibrx_pkg::MAX_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ibrx_byte_if.sink   rx,
	ibrx_res_if.source  res,
	ibrx_cfg_if.sink    cfg
);

	logic [ibrx_pkg::CNT_W-1:0]    channel_count_q;
	logic                          busy;
	logic                          st_we;
	logic [ibrx_pkg::STORE_AW-1:0] st_waddr;
	logic [ibrx_pkg::BYTE_W-1:0]   st_wdata;
	logic                          st_re;
	logic [ibrx_pkg::STORE_AW-1:0] st_raddr;
	logic [ibrx_pkg::BYTE_W-1:0]   st_rdata;
	ibrx_pkg::frame_end_t          fe;

	// Channel count register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= ibrx_pkg::CHANNEL_COUNT_RST;
		end else if (cfg.valid && cfg.ready) begin
			channel_count_q <= cfg.channel_count;
		end
	end

	ibrx_intake u_intake (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.busy     (busy),
		.st_we    (st_we),
		.st_waddr (st_waddr),
		.st_wdata (st_wdata),
		.fe       (fe)
	);

	ibrx_store u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	ibrx_emit #(
		.BASE_SLOTS   (BASE_SLOTS),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.fe            (fe),
		.channel_count (channel_count_q),
		.busy          (busy),
		.st_re         (st_re),
		.st_raddr      (st_raddr),
		.st_rdata      (st_rdata),
		.res           (res)
	);

endmodule

// File: rtl/ibrx_checker.sv
// ----------------------------------------------------------------------------
// ibrx_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ibrx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_status,
	input logic        res_has_value,
	input logic [4:0]  res_channel_index,
	input logic [11:0] res_channel_value,
	input logic        res_receiver_model,
	input logic        res_last
);

	// Stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
		&& $stable(res_has_value) && $stable(res_channel_index)
		&& $stable(res_channel_value) && $stable(res_receiver_model) && $stable(res_last))
		else $error("result changed while stalled");

	// No byte transfer while a frame's results are still being built
	a_no_rx_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !rx_ready)
		else $error("byte input open before last result");

	// Status-only result is the sole one of its frame
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_has_value |-> res_last && res_channel_index == 5'd0
		&& res_channel_value == 12'd0)
		else $error("malformed status-only result");

	// Checksum error carries no channel
	a_err_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status |-> !res_has_value)
		else $error("channel reported on checksum error");

endmodule

bind ibus_rc_frame_receiver ibrx_checker u_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rx_ready           (rx.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_status         (res.status),
	.res_has_value      (res.has_value),
	.res_channel_index  (res.channel_index),
	.res_channel_value  (res.channel_value),
	.res_receiver_model (res.receiver_model),
	.res_last           (res.last)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-model RC serial frame receiver.
// ----------------------------------------------------------------------------
// Bytes go in through a queue-fed driver, and results are checked in order
// against a predictor of the frame parser. Older-model frames come first,
// since they can only start before a newer-model sync byte is seen. Newer
// frames, telemetry frames, bad checksums and noise follow, with the channel
// count changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int TAIL_CYCLES    = 100;
	localparam int BYTE_TARGET    = 400;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	typedef struct {
		logic        status;
		logic        has_value;
		logic [4:0]  channel_index;
		logic [11:0] channel_value;
		logic        receiver_model;
		logic        last;
	} chan_res_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Values driven onto the channels
	logic       drv_valid  = 1'b0;
	logic [7:0] drv_byte   = 8'h00;
	logic       take_ready = 1'b0;
	logic       cfg_valid  = 1'b0;
	logic [4:0] cfg_data   = 5'd0;
	bit         steady     = 1'b0;
	bit         rx_taken   = 1'b0;

	logic [7:0]  byte_q[$];
	chan_res_t   want_q[$];
	int          n_pushed = 0;
	int          n_taken  = 0;
	int          errs     = 0;
	int          quiet    = 0;
	logic [7:0]  gen_sync = 8'h00;

	// Predictor state
	logic [4:0] chan_cfg = ibrx_pkg::CHANNEL_COUNT_RST;
	bit         framing  = 1'b0;
	bit         mdl_new  = 1'b0;
	logic [7:0] sync_b   = 8'h00;
	logic [5:0] flen     = 6'd0;
	logic [5:0] wpos     = 6'd0;
	logic [7:0] fr_store [32];

	// Coverage tallies for the summary
	int cnt_old = 0, cnt_new = 0, cnt_telem = 0, cnt_bad = 0, cnt_chan = 0, cnt_cfg = 0;

	ibrx_byte_if rx_if ();
	ibrx_res_if  res_if ();
	ibrx_cfg_if  cfg_if ();

	assign rx_if.valid          = drv_valid;
	assign rx_if.rx_byte        = drv_byte;
	assign res_if.ready         = take_ready;
	assign cfg_if.valid         = cfg_valid;
	assign cfg_if.channel_count = cfg_data;

	ibus_rc_frame_receiver DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(string what);
		errs++;
		$display("mismatch: %s", what);
	endtask

	function void add_result(logic st, logic hv, int idx, logic [11:0] val, logic lst);
		chan_res_t r;
		r.status         = st;
		r.has_value      = hv;
		r.channel_index  = 5'(idx);
		r.channel_value  = val;
		r.receiver_model = mdl_new;
		r.last           = lst;
		want_q.push_back(r);
	endfunction

	// Checksum over the stored frame, per model
	function bit frame_sum_ok();
		logic [15:0] acc;
		logic [15:0] trail;
		int i;
		if (mdl_new) begin
			acc = ibrx_pkg::NEW_SUM_SEED;
			for (i = 0; i + 2 < int'(flen); i++)
				acc = acc - 16'(fr_store[i & 31]);
			trail = {fr_store[(flen - 1) & 31], fr_store[(flen - 2) & 31]};
		end else begin
			acc = 16'h0000;
			for (i = 0; i < 14; i++)
				acc = acc + {fr_store[(2 + 2 * i) & 31], fr_store[(1 + 2 * i) & 31]};
			trail = {fr_store[30], fr_store[29]};
		end
		return acc == trail;
	endfunction

	// Results of a completed frame
	function void close_frame();
		int n, base, i, o, off;
		logic [11:0] v;
		if (mdl_new) cnt_new++; else cnt_old++;
		if (!frame_sum_ok()) begin
			cnt_bad++;
			add_result(1'b1, 1'b0, 0, 12'h000, 1'b1);
			return;
		end
		if (mdl_new && flen == ibrx_pkg::TELEM_FRAME_LEN) begin
			cnt_telem++;
			add_result(1'b0, 1'b0, 0, 12'h000, 1'b1);
			return;
		end
		n = (int'(chan_cfg) < ibrx_pkg::MAX_CHANNELS_DEF) ? int'(chan_cfg)
			: ibrx_pkg::MAX_CHANNELS_DEF;
		if (n == 0) begin
			add_result(1'b0, 1'b0, 0, 12'h000, 1'b1);
			return;
		end
		base = (n < ibrx_pkg::BASE_SLOTS_DEF) ? n : ibrx_pkg::BASE_SLOTS_DEF;
		off  = mdl_new ? 2 : 1;
		for (i = 0; i < base; i++) begin
			o = off + 2 * i;
			v = {fr_store[(o + 1) & 31][3:0], fr_store[o & 31]};
			add_result(1'b0, 1'b1, i, v, i + 1 == n);
		end
		// extra channels from high nibbles
		o = off + 1;
		for (; i < n; i++) begin
			v = {fr_store[(o + 4) & 31][7:4], fr_store[(o + 2) & 31][7:4],
				fr_store[o & 31][7:4]};
			add_result(1'b0, 1'b1, i, v, i + 1 == n);
			o += 6;
		end
		cnt_chan += n;
	endfunction

	// One accepted byte through the parser
	function void absorb_byte(logic [7:0] b);
		if (!framing) begin
			if (b == ibrx_pkg::RX_FRAME_LEN || b == ibrx_pkg::TELEM_FRAME_LEN) begin
				mdl_new = 1'b1;
				sync_b  = b;
				flen    = b[5:0];
			end else if (sync_b == 8'h00 && b == ibrx_pkg::OLD_START) begin
				mdl_new = 1'b0;
				sync_b  = b;
				flen    = 6'(ibrx_pkg::OLD_FRAME_LEN);
			end else if (sync_b == 8'h00 || sync_b != b) begin
				return;
			end
			framing = 1'b1;
			wpos    = 6'd0;
		end
		fr_store[wpos[4:0]] = b;
		wpos = wpos + 6'd1;
		if (wpos == flen) begin
			framing = 1'b0;
			close_frame();
		end
	endfunction

	task automatic check_result();
		chan_res_t want;
		if (want_q.size() == 0) begin
			report_mismatch("result with nothing expected");
			return;
		end
		want = want_q.pop_front();
		if (res_if.status !== want.status || res_if.has_value !== want.has_value ||
				res_if.channel_index !== want.channel_index ||
				res_if.channel_value !== want.channel_value ||
				res_if.receiver_model !== want.receiver_model || res_if.last !== want.last)
			report_mismatch($sformatf(
				{"got st=%0b hv=%0b ch=%0d val=%h mdl=%0b last=%0b, ",
					"want st=%0b hv=%0b ch=%0d val=%h mdl=%0b last=%0b"},
				res_if.status, res_if.has_value, res_if.channel_index, res_if.channel_value,
				res_if.receiver_model, res_if.last, want.status, want.has_value,
				want.channel_index, want.channel_value, want.receiver_model, want.last));
	endtask

	// Byte driver: hold until transfer, then next byte or a random idle
	always @(negedge clk) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (!drv_valid || rx_taken) begin
			if (byte_q.size() > 0 && (steady || $urandom_range(0, 99) >= 25)) begin
				drv_valid <= 1'b1;
				drv_byte  <= byte_q.pop_front();
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		take_ready <= arst_n && (steady || $urandom_range(0, 99) >= 25);
	end

	// Monitor: byte, result and register transfers, plus the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			rx_taken = drv_valid && rx_if.ready;
			if (rx_taken) begin
				absorb_byte(drv_byte);
				n_taken++;
			end
			if (res_if.valid && take_ready)
				check_result();
			if (cfg_valid && cfg_if.ready)
				chan_cfg = cfg_data;
			if (rx_taken || (res_if.valid && take_ready) || (cfg_valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	function void push_byte(logic [7:0] b);
		byte_q.push_back(b);
		n_pushed++;
	endfunction

	// Bytes that start nothing in the current hunt state
	function void queue_noise(int k);
		logic [7:0] b;
		repeat (k) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == ibrx_pkg::RX_FRAME_LEN || b == ibrx_pkg::TELEM_FRAME_LEN ||
				(gen_sync != 8'h00 && b == gen_sync) ||
				(gen_sync == 8'h00 && b == ibrx_pkg::OLD_START));
			push_byte(b);
		end
	endfunction

	// Whole frame with correct trailer, or one byte spoiled
	function void queue_frame(bit newer, int len, fill_t fill, bit good);
		logic [7:0]  fb [32];
		logic [15:0] acc;
		int i, pos;
		fb[0] = newer ? 8'(len) : ibrx_pkg::OLD_START;
		for (i = 1; i < len - 2; i++)
			case (fill)
				FILL_ZERO: fb[i] = 8'h00;
				FILL_ONES: fb[i] = 8'hFF;
				default:   fb[i] = 8'($urandom_range(0, 255));
			endcase
		if (newer) begin
			acc = ibrx_pkg::NEW_SUM_SEED;
			for (i = 0; i < len - 2; i++)
				acc = acc - 16'(fb[i]);
		end else begin
			acc = 16'h0000;
			for (i = 0; i < 14; i++)
				acc = acc + {fb[2 + 2 * i], fb[1 + 2 * i]};
		end
		fb[len - 2] = acc[7:0];
		fb[len - 1] = acc[15:8];
		if (!good) begin
			pos = $urandom_range(1, len - 1);
			fb[pos] = fb[pos] ^ 8'($urandom_range(1, 255));
		end
		for (i = 0; i < len; i++)
			push_byte(fb[i]);
		gen_sync = fb[0];
	endfunction

	task automatic wait_drained();
		do begin
			@(posedge clk);
			#1;
		end while (n_taken != n_pushed || want_q.size() != 0);
	endtask

	task automatic write_channel_count(logic [4:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cnt_cfg++;
		#1;
	endtask

	function logic [4:0] pick_setting();
		case ($urandom_range(0, 5))
			0:       return 5'd31;
			1:       return 5'd18;
			2:       return 5'd0;
			3:       return 5'd1;
			default: return 5'($urandom_range(0, 31));
		endcase
	endfunction

	// A run of random frames; older model only before any newer sync
	task automatic run_phase(bit older, int nfr, bit drain_mid);
		int j, r;
		for (j = 0; j < nfr; j++) begin
			if ($urandom_range(0, 99) < 30)
				queue_noise($urandom_range(1, 3));
			r = $urandom_range(0, 99);
			if (older)
				queue_frame(1'b0, ibrx_pkg::OLD_FRAME_LEN, FILL_RANDOM, r < 75);
			else if (r < 70)
				queue_frame(1'b1, ibrx_pkg::RX_FRAME_LEN, FILL_RANDOM, 1'b1);
			else if (r < 80)
				queue_frame(1'b1, ibrx_pkg::RX_FRAME_LEN, FILL_RANDOM, 1'b0);
			else
				queue_frame(1'b1, ibrx_pkg::TELEM_FRAME_LEN, FILL_RANDOM, r < 92);
			if (drain_mid && j == 0)
				wait_drained();
		end
	endtask

	// Stimulus sequence
	initial begin
		int ph;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		#1;

		// Older model, directed: zero byte and noise while hunting, extremes
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h01);
		queue_frame(1'b0, ibrx_pkg::OLD_FRAME_LEN, FILL_ONES, 1'b1);
		write_channel_count(5'd31);
		queue_frame(1'b0, ibrx_pkg::OLD_FRAME_LEN, FILL_ZERO, 1'b1);
		push_byte(8'h00);

		// Older model, random
		for (ph = 0; ph < 2; ph++) begin
			write_channel_count(pick_setting());
			run_phase(1'b1, $urandom_range(1, 2), ph == 1);
		end

		// Newer model, directed: telemetry, stale start byte, zero channels
		queue_frame(1'b1, ibrx_pkg::TELEM_FRAME_LEN, FILL_RANDOM, 1'b1);
		queue_frame(1'b1, ibrx_pkg::TELEM_FRAME_LEN, FILL_RANDOM, 1'b0);
		push_byte(ibrx_pkg::OLD_START);
		write_channel_count(5'd0);
		queue_frame(1'b1, ibrx_pkg::RX_FRAME_LEN, FILL_RANDOM, 1'b1);
		write_channel_count(5'd18);
		queue_frame(1'b1, ibrx_pkg::RX_FRAME_LEN, FILL_ONES, 1'b1);

		// Newer model, random phases; the first one runs with no idling
		ph = 0;
		while (n_pushed < BYTE_TARGET) begin
			write_channel_count(pick_setting());
			steady = (ph == 0);
			run_phase(1'b0, (ph == 0) ? 4 : $urandom_range(1, 3), ph == 1);
			ph++;
		end
		steady = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d bytes, %0d register writes, %0d older and %0d newer frames",
			n_taken, cnt_cfg, cnt_old, cnt_new);
		$display("of these %0d telemetry, %0d checksum errors; %0d channel values checked",
			cnt_telem, cnt_bad, cnt_chan);
		if (errs == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
